### sv/alu16f_pkg.sv
// ----------------------------------------------------------------------------
// alu16f_pkg
// Operation codes, widths and flag layout shared by the 16-bit ALU.
// ----------------------------------------------------------------------------
package alu16f_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned FuncW = 5;

  // Operation codes, in the order the instruction set defines them.
  localparam logic [FuncW-1:0] OP_ADD   = 5'd0;
  localparam logic [FuncW-1:0] OP_ADDC  = 5'd1;
  localparam logic [FuncW-1:0] OP_AND   = 5'd2;
  localparam logic [FuncW-1:0] OP_BIC   = 5'd3;
  localparam logic [FuncW-1:0] OP_ASL   = 5'd4;
  localparam logic [FuncW-1:0] OP_ASR   = 5'd5;
  localparam logic [FuncW-1:0] OP_DECA  = 5'd6;
  localparam logic [FuncW-1:0] OP_INCA  = 5'd7;
  localparam logic [FuncW-1:0] OP_LSL   = 5'd8;
  localparam logic [FuncW-1:0] OP_LSR   = 5'd9;
  localparam logic [FuncW-1:0] OP_NAND  = 5'd10;
  localparam logic [FuncW-1:0] OP_NOR   = 5'd11;
  localparam logic [FuncW-1:0] OP_ONES  = 5'd12;
  localparam logic [FuncW-1:0] OP_OR    = 5'd13;
  localparam logic [FuncW-1:0] OP_ORN   = 5'd14;
  localparam logic [FuncW-1:0] OP_MOVA  = 5'd15;
  localparam logic [FuncW-1:0] OP_NOTA  = 5'd16;
  localparam logic [FuncW-1:0] OP_SUB   = 5'd17;
  localparam logic [FuncW-1:0] OP_SUBB  = 5'd18;
  localparam logic [FuncW-1:0] OP_XNOR  = 5'd19;
  localparam logic [FuncW-1:0] OP_XOR   = 5'd20;
  localparam logic [FuncW-1:0] OP_CLR   = 5'd21;
  localparam logic [FuncW-1:0] OP_LDI   = 5'd22;
  localparam logic [FuncW-1:0] OP_LCH   = 5'd23;
  localparam logic [FuncW-1:0] OP_LCL   = 5'd24;

  // Range of codes that change nothing.
  localparam logic [FuncW-1:0] OP_UNUSED_LO = 5'd25;
  localparam logic [FuncW-1:0] OP_UNUSED_HI = 5'd31;

  // Masks for the byte loads.
  localparam logic [WordW-1:0] LowByteMask  = 16'h00FF;
  localparam logic [WordW-1:0] HighByteMask = 16'hFF00;

  // How carry and overflow are formed for an operation.
  typedef enum logic [1:0] {
    KIND_LOGIC = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_SUB   = 2'd2,
    KIND_SHIFT = 2'd3
  } op_kind_t;

  typedef struct packed {
    logic neg;
    logic zero;
    logic neg_or_zero;
    logic nonzero;
    logic carry;
    logic overflow;
  } flags_t;

endpackage

### sv/alu_16bit_with_flags_core.sv
// ----------------------------------------------------------------------------
// alu_16bit_with_flags_core
// 16-bit ALU with a held result word and six status flags.
// ----------------------------------------------------------------------------
// The ALU accepts one item per clock cycle while in_stall is low and returns
// exactly one result item for each item it accepts. An item first lands in
// an input register; from there a single adder plus the logic and shift
// selection compute the new word and flags, which are written into the result
// register that also serves as the held ALU state. The result register lets a
// new item enter while a finished result still waits to be taken, so the input
// side only stalls when both registers are full and the output is stalled.
// Codes 0 to 24 update the word; the literal load and the two byte loads keep
// the previous flags; codes 25 to 31 change nothing and report the held word
// and flags again. Flags after reset are all clear and the held word is zero.
module alu_16bit_with_flags_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] operand_a,
  input  logic [15:0] operand_b,
  input  logic [4:0]  func,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] result,
  output logic        flag_neg,
  output logic        flag_zero,
  output logic        flag_neg_or_zero,
  output logic        flag_nonzero,
  output logic        flag_carry,
  output logic        flag_overflow
);

  // Input register.
  logic                              s1_valid;
  logic [alu16f_pkg::WordW-1:0]      s1_a;
  logic [alu16f_pkg::WordW-1:0]      s1_b;
  logic [alu16f_pkg::FuncW-1:0]      s1_func;

  // Result register, which is also the held ALU state.
  logic [alu16f_pkg::WordW-1:0]      word;
  alu16f_pkg::flags_t                flags;

  logic                              advance;
  logic                              in_take;

  // The output register is free when empty or being drained this cycle.
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_take  = in_valid && !in_stall;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_a    <= operand_a;
      s1_b    <= operand_b;
      s1_func <= func;
    end
  end

  // Single adder shared by the add and subtract families. Subtraction adds
  // the inverted B operand; INCA and DECA add one or all ones to A.
  logic [alu16f_pkg::WordW-1:0] addend;
  logic                         cin;
  logic [alu16f_pkg::WordW-1:0] sum;

  logic [alu16f_pkg::WordW-1:0] r_next;
  alu16f_pkg::op_kind_t         kind;
  logic                         upd_word;
  logic                         upd_flags;
  alu16f_pkg::flags_t           flags_next;

  logic a15;
  logic a14;
  logic b15;
  logic r15;

  always_comb begin
    addend = s1_b;
    cin    = 1'b0;
    case (s1_func)
      alu16f_pkg::OP_ADDC: begin
        cin = 1'b1;
      end
      alu16f_pkg::OP_DECA: begin
        addend = '1;
      end
      alu16f_pkg::OP_INCA: begin
        addend = '0;
        cin    = 1'b1;
      end
      alu16f_pkg::OP_SUB: begin
        addend = ~s1_b;
        cin    = 1'b1;
      end
      alu16f_pkg::OP_SUBB: begin
        addend = ~s1_b;
      end
      default: begin
        addend = s1_b;
      end
    endcase
  end

  assign sum = s1_a + addend + {{(alu16f_pkg::WordW-1){1'b0}}, cin};

  always_comb begin
    r_next    = word;
    kind      = alu16f_pkg::KIND_LOGIC;
    upd_word  = 1'b1;
    upd_flags = 1'b1;
    case (s1_func)
      alu16f_pkg::OP_ADD, alu16f_pkg::OP_ADDC, alu16f_pkg::OP_INCA: begin
        r_next = sum;
        kind   = alu16f_pkg::KIND_ADD;
      end
      alu16f_pkg::OP_SUB, alu16f_pkg::OP_SUBB, alu16f_pkg::OP_DECA: begin
        r_next = sum;
        kind   = alu16f_pkg::KIND_SUB;
      end
      alu16f_pkg::OP_AND:        r_next = s1_a & s1_b;
      alu16f_pkg::OP_BIC:        r_next = ~s1_a & s1_b;
      alu16f_pkg::OP_ASL, alu16f_pkg::OP_LSL: begin
        r_next = {s1_a[alu16f_pkg::WordW-2:0], 1'b0};
        kind   = alu16f_pkg::KIND_SHIFT;
      end
      alu16f_pkg::OP_ASR: begin
        r_next = {s1_a[alu16f_pkg::WordW-1], s1_a[alu16f_pkg::WordW-1:1]};
      end
      alu16f_pkg::OP_LSR:        r_next = {1'b0, s1_a[alu16f_pkg::WordW-1:1]};
      alu16f_pkg::OP_NAND:       r_next = ~(s1_a & s1_b);
      alu16f_pkg::OP_NOR:        r_next = ~(s1_a | s1_b);
      alu16f_pkg::OP_ONES:       r_next = {{(alu16f_pkg::WordW-1){1'b0}}, 1'b1};
      alu16f_pkg::OP_OR:         r_next = s1_a | s1_b;
      alu16f_pkg::OP_ORN:        r_next = s1_a | ~s1_b;
      alu16f_pkg::OP_MOVA:       r_next = s1_a;
      alu16f_pkg::OP_NOTA:       r_next = ~s1_a;
      alu16f_pkg::OP_XNOR:       r_next = ~(s1_a ^ s1_b);
      alu16f_pkg::OP_XOR:        r_next = s1_a ^ s1_b;
      alu16f_pkg::OP_CLR:        r_next = '0;
      alu16f_pkg::OP_LDI: begin
        r_next    = s1_b;
        upd_flags = 1'b0;
      end
      alu16f_pkg::OP_LCH: begin
        r_next    = (s1_a & alu16f_pkg::LowByteMask) | {s1_b[7:0], 8'h00};
        upd_flags = 1'b0;
      end
      alu16f_pkg::OP_LCL: begin
        r_next    = (s1_a & alu16f_pkg::HighByteMask) | (s1_b & alu16f_pkg::LowByteMask);
        upd_flags = 1'b0;
      end
      default: begin
        // Unused codes leave the word and flags as they are.
        upd_word  = 1'b0;
        upd_flags = 1'b0;
      end
    endcase
  end

  assign a15 = s1_a[alu16f_pkg::WordW-1];
  assign a14 = s1_a[alu16f_pkg::WordW-2];
  assign b15 = s1_b[alu16f_pkg::WordW-1];
  assign r15 = r_next[alu16f_pkg::WordW-1];

  // Carry and overflow use the B operand as given, also for INCA and DECA.
  always_comb begin
    flags_next.neg         = r15;
    flags_next.zero        = (r_next == '0);
    flags_next.neg_or_zero = r15 || (r_next == '0);
    flags_next.nonzero     = (r_next != '0);
    flags_next.carry       = 1'b0;
    flags_next.overflow    = 1'b0;
    case (kind)
      alu16f_pkg::KIND_ADD: begin
        flags_next.carry    = (a15 & b15) | ((a15 | b15) & ~r15);
        flags_next.overflow = (a15 == b15) && (r15 != a15);
      end
      alu16f_pkg::KIND_SUB: begin
        flags_next.carry    = (a15 & b15) | ((a15 | b15) & ~r15);
        flags_next.overflow = (a15 != b15) && (r15 != a15);
      end
      alu16f_pkg::KIND_SHIFT: begin
        flags_next.carry    = a15;
        flags_next.overflow = (s1_func == alu16f_pkg::OP_ASL) && (a15 ^ a14);
      end
      default: begin
        flags_next.carry    = 1'b0;
        flags_next.overflow = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      word      <= '0;
      flags     <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        if (upd_word) begin
          word <= r_next;
        end
        if (upd_flags) begin
          flags <= flags_next;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result           = word;
  assign flag_neg         = flags.neg;
  assign flag_zero        = flags.zero;
  assign flag_neg_or_zero = flags.neg_or_zero;
  assign flag_nonzero     = flags.nonzero;
  assign flag_carry       = flags.carry;
  assign flag_overflow    = flags.overflow;

`ifndef SYNTH
  // An accepted item always lands in the input register.
  a_take_lands: assert property (@(posedge clk) disable iff (rst)
    in_take |=> s1_valid)
    else $error("accepted item did not reach the input register");

  // A held item moves on when the output register is empty.
  a_fill_out: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_valid |=> out_valid)
    else $error("output register not filled from a waiting item");

  // Unused codes leave the held word untouched.
  a_unused_holds: assert property (@(posedge clk) disable iff (rst)
    advance && (s1_func > alu16f_pkg::OP_LCL) |=> $stable(result))
    else $error("unused code changed the result word");

  // The negative-or-zero flag is always formed from the other two.
  a_nz_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> flag_neg_or_zero == (flag_neg || flag_zero))
    else $error("negative-or-zero flag inconsistent");
`endif

endmodule
